FILE: hw/rtl/spsu_pkg.sv
// ----------------------------------------------------------------------------
// SoC power sequencer package
// Shared types, register indexes and reset values of the power sequencer.
// ----------------------------------------------------------------------------
package spsu_pkg;

   localparam int TickW     = 16;
   localparam int CsrIndexW = 8;
   localparam int ReqDataW  = 8;
   localparam int RspDataW  = 16;

   // Configuration register indexes.
   localparam logic [CsrIndexW-1:0] REG_DEBOUNCE   = 8'd0;
   localparam logic [CsrIndexW-1:0] REG_LONG_PRESS = 8'd1;
   localparam logic [CsrIndexW-1:0] REG_BOOT_DELAY = 8'd2;
   localparam logic [CsrIndexW-1:0] REG_PULSE      = 8'd3;

   localparam logic [TickW-1:0] DEBOUNCE_RESET   = 16'd50;
   localparam logic [TickW-1:0] LONG_PRESS_RESET = 16'd5000;
   localparam logic [TickW-1:0] BOOT_DELAY_RESET = 16'd5000;
   localparam logic [TickW-1:0] PULSE_RESET      = 16'd500;
   localparam logic [TickW-1:0] TICK_MAX         = 16'hFFFF;

   typedef enum logic [2:0] {
      MODE_OFF   = 3'd0,
      MODE_START = 3'd1,
      MODE_COLD  = 3'd2,
      MODE_ON    = 3'd3,
      MODE_RESET = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      STEP_IDLE     = 3'd0,
      STEP_S_BOOT   = 3'd1,
      STEP_C_PULSE  = 3'd2,
      STEP_C_SETTLE = 3'd3,
      STEP_C_BOOT   = 3'd4
   } step_type;

   typedef struct packed {
      logic [TickW-1:0] debounce_ticks;
      logic [TickW-1:0] long_press_ticks;
      logic [TickW-1:0] boot_delay_ticks;
      logic [TickW-1:0] pulse_ticks;
   } cfg_type;

   typedef struct packed {
      logic qspi_enable;
      logic emmc_enable;
      logic sd_enable;
      logic reset_out;
      logic pmic_reset;
      logic pwron_out;
   } drive_type;

   // Input item, last field in the lowest bit.
   typedef struct packed {
      logic cold_start_req;
      logic force_recov;
      logic reset_in;
      logic power_btn;
   } req_type;

   // Result item, last field in the lowest bit.
   typedef struct packed {
      logic     busy_res;
      mode_type soc_phase;
      logic     qspi_enable;
      logic     emmc_enable;
      logic     sd_enable;
      logic     reset_out;
      logic     pmic_reset;
      logic     pwron_out;
   } rsp_type;

   typedef struct packed {
      step_type         step;
      logic [TickW-1:0] timer;
      drive_type        drive;
      logic             done;
   } phase_type;

endpackage

FILE: hw/rtl/spsu_cfg_regs.sv
// ----------------------------------------------------------------------------
// SoC power sequencer configuration registers
// Holds the four tick counts; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module spsu_cfg_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [spsu_pkg::CsrIndexW-1:0]   wr_index,
   input  logic [spsu_pkg::TickW-1:0]       wr_data,
   output spsu_pkg::cfg_type                cfg
);

   spsu_pkg::cfg_type cfg_ff;
   spsu_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            spsu_pkg::REG_DEBOUNCE:   cfg_in.debounce_ticks   = wr_data;
            spsu_pkg::REG_LONG_PRESS: cfg_in.long_press_ticks = wr_data;
            spsu_pkg::REG_BOOT_DELAY: cfg_in.boot_delay_ticks = wr_data;
            spsu_pkg::REG_PULSE:      cfg_in.pulse_ticks      = wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks   <= spsu_pkg::DEBOUNCE_RESET;
         cfg_ff.long_press_ticks <= spsu_pkg::LONG_PRESS_RESET;
         cfg_ff.boot_delay_ticks <= spsu_pkg::BOOT_DELAY_RESET;
         cfg_ff.pulse_ticks      <= spsu_pkg::PULSE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hw/rtl/spsu_core.sv
// ----------------------------------------------------------------------------
// SoC power sequencer core
// Mode and sequence state, press timer and edge detectors, advanced by one
// tick whenever an item is processed.
// ----------------------------------------------------------------------------
module spsu_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  spsu_pkg::req_type    item,
   input  spsu_pkg::cfg_type    cfg,
   output spsu_pkg::rsp_type    result
);

   spsu_pkg::mode_type              mode_ff, mode_in;
   spsu_pkg::mode_type              seen_ff, seen_in;
   spsu_pkg::step_type              step_ff, step_in;
   logic [spsu_pkg::TickW-1:0]      timer_ff, timer_in;
   logic [spsu_pkg::TickW-1:0]      press_ff, press_in;
   logic                            btn_last_ff, btn_last_in;
   logic                            rst_last_ff, rst_last_in;
   logic                            recov_ff, recov_in;
   spsu_pkg::drive_type             drive_ff, drive_in;
   spsu_pkg::phase_type             phase;
   logic [spsu_pkg::TickW-1:0]      timer_dec;

   // Ends every phase whose timer has run out, up to the three that can
   // chain within one tick.
   function automatic spsu_pkg::phase_type run_phases(
      input spsu_pkg::step_type         step,
      input logic [spsu_pkg::TickW-1:0] timer,
      input spsu_pkg::drive_type        drive,
      input logic                       recov,
      input logic [spsu_pkg::TickW-1:0] pulse,
      input logic [spsu_pkg::TickW-1:0] boot
   );
      spsu_pkg::phase_type r;
      r.step  = step;
      r.timer = timer;
      r.drive = drive;
      r.done  = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (r.step != spsu_pkg::STEP_IDLE && r.timer == '0) begin
            case (r.step)
               spsu_pkg::STEP_C_PULSE: begin
                  r.drive.pwron_out = 1'b0;
                  if (recov) begin
                     r.drive.sd_enable   = 1'b1;
                     r.drive.emmc_enable = 1'b1;
                     r.drive.qspi_enable = 1'b1;
                  end
                  r.step  = spsu_pkg::STEP_C_SETTLE;
                  r.timer = pulse;
               end
               spsu_pkg::STEP_C_SETTLE: begin
                  r.drive.pmic_reset = 1'b0;
                  if (recov) begin
                     r.step  = spsu_pkg::STEP_IDLE;
                     r.timer = '0;
                     r.done  = 1'b1;
                  end else begin
                     r.step  = spsu_pkg::STEP_C_BOOT;
                     r.timer = boot;
                  end
               end
               default: begin
                  r.drive.sd_enable   = 1'b1;
                  r.drive.emmc_enable = 1'b1;
                  r.drive.qspi_enable = 1'b1;
                  r.step  = spsu_pkg::STEP_IDLE;
                  r.timer = '0;
                  r.done  = 1'b1;
               end
            endcase
         end
      end
      return r;
   endfunction

   assign timer_dec = (timer_ff != '0) ? timer_ff - 1'b1 : '0;

   // Next state.
   always_comb begin
      mode_in     = mode_ff;
      seen_in     = seen_ff;
      step_in     = step_ff;
      timer_in    = timer_ff;
      drive_in    = drive_ff;
      recov_in    = recov_ff;
      btn_last_in = btn_last_ff;
      rst_last_in = rst_last_ff;
      press_in    = (press_ff == spsu_pkg::TICK_MAX) ? press_ff : press_ff + 1'b1;
      phase       = '0;

      if (step_ff != spsu_pkg::STEP_IDLE) begin
         phase = run_phases(step_ff, timer_dec, drive_ff, recov_ff,
                            cfg.pulse_ticks, cfg.boot_delay_ticks);
         step_in  = phase.step;
         timer_in = phase.timer;
         drive_in = phase.drive;
         if (phase.done) begin
            mode_in = spsu_pkg::MODE_ON;
            seen_in = spsu_pkg::MODE_ON;
         end
      end else begin
         if (item.cold_start_req) begin
            mode_in = spsu_pkg::MODE_COLD;
         end
         if (mode_in != seen_ff) begin
            seen_in = mode_in;
            case (mode_in)
               spsu_pkg::MODE_OFF: begin
                  drive_in.pmic_reset  = 1'b1;
                  drive_in.sd_enable   = 1'b0;
                  drive_in.emmc_enable = 1'b0;
                  drive_in.qspi_enable = 1'b0;
               end
               spsu_pkg::MODE_RESET: begin
                  drive_in.pmic_reset  = 1'b1;
                  drive_in.sd_enable   = 1'b0;
                  drive_in.emmc_enable = 1'b0;
                  drive_in.qspi_enable = 1'b0;
                  drive_in.reset_out   = 1'b0;
               end
               spsu_pkg::MODE_START: begin
                  recov_in            = item.force_recov;
                  drive_in.pmic_reset = 1'b0;
                  drive_in.sd_enable  = 1'b1;
                  if (item.force_recov) begin
                     drive_in.emmc_enable = 1'b1;
                     drive_in.qspi_enable = 1'b1;
                     mode_in = spsu_pkg::MODE_ON;
                     seen_in = spsu_pkg::MODE_ON;
                  end else begin
                     drive_in.emmc_enable = 1'b0;
                     drive_in.qspi_enable = 1'b0;
                     phase = run_phases(spsu_pkg::STEP_S_BOOT, cfg.boot_delay_ticks,
                                        drive_in, 1'b0, cfg.pulse_ticks,
                                        cfg.boot_delay_ticks);
                     step_in  = phase.step;
                     timer_in = phase.timer;
                     drive_in = phase.drive;
                     if (phase.done) begin
                        mode_in = spsu_pkg::MODE_ON;
                        seen_in = spsu_pkg::MODE_ON;
                     end
                  end
               end
               spsu_pkg::MODE_COLD: begin
                  recov_in           = item.force_recov;
                  drive_in.reset_out = 1'b1;
                  if (!item.force_recov) begin
                     drive_in.sd_enable   = 1'b1;
                     drive_in.emmc_enable = 1'b0;
                     drive_in.qspi_enable = 1'b0;
                  end
                  drive_in.pwron_out = 1'b1;
                  phase = run_phases(spsu_pkg::STEP_C_PULSE, cfg.pulse_ticks, drive_in,
                                     item.force_recov, cfg.pulse_ticks,
                                     cfg.boot_delay_ticks);
                  step_in  = phase.step;
                  timer_in = phase.timer;
                  drive_in = phase.drive;
                  if (phase.done) begin
                     mode_in = spsu_pkg::MODE_ON;
                     seen_in = spsu_pkg::MODE_ON;
                  end
               end
               default: ;
            endcase
         end
      end

      // Edges are only looked at while no phase runs.
      if (step_in == spsu_pkg::STEP_IDLE) begin
         drive_in.pwron_out = ~item.power_btn;
         if (btn_last_ff && !item.power_btn) begin
            press_in = '0;
         end else if (!btn_last_ff && item.power_btn) begin
            if (press_in >= cfg.debounce_ticks && press_in < cfg.long_press_ticks) begin
               if (mode_in == spsu_pkg::MODE_OFF) begin
                  mode_in = spsu_pkg::MODE_START;
               end
            end else if (press_in >= cfg.long_press_ticks) begin
               mode_in = spsu_pkg::MODE_OFF;
            end
         end
         btn_last_in = item.power_btn;

         if (!rst_last_ff && item.reset_in) begin
            if (mode_in == spsu_pkg::MODE_RESET) begin
               mode_in = spsu_pkg::MODE_START;
            end
         end else if (rst_last_ff && !item.reset_in) begin
            if (mode_in == spsu_pkg::MODE_ON) begin
               mode_in = spsu_pkg::MODE_RESET;
            end
         end
         rst_last_in = item.reset_in;
      end
   end

   // Result of the tick, taken from the state after it.
   always_comb begin
      result.pwron_out   = drive_in.pwron_out;
      result.pmic_reset  = drive_in.pmic_reset;
      result.reset_out   = drive_in.reset_out;
      result.sd_enable   = drive_in.sd_enable;
      result.emmc_enable = drive_in.emmc_enable;
      result.qspi_enable = drive_in.qspi_enable;
      result.soc_phase   = mode_in;
      result.busy_res    = (step_in != spsu_pkg::STEP_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= spsu_pkg::MODE_OFF;
         seen_ff     <= spsu_pkg::MODE_OFF;
         step_ff     <= spsu_pkg::STEP_IDLE;
         timer_ff    <= '0;
         press_ff    <= '0;
         btn_last_ff <= 1'b1;
         rst_last_ff <= 1'b1;
         recov_ff    <= 1'b0;
         drive_ff    <= '{qspi_enable: 1'b0, emmc_enable: 1'b0, sd_enable: 1'b0,
                          reset_out: 1'b1, pmic_reset: 1'b1, pwron_out: 1'b0};
      end else if (advance) begin
         mode_ff     <= mode_in;
         seen_ff     <= seen_in;
         step_ff     <= step_in;
         timer_ff    <= timer_in;
         press_ff    <= press_in;
         btn_last_ff <= btn_last_in;
         rst_last_ff <= rst_last_in;
         recov_ff    <= recov_in;
         drive_ff    <= drive_in;
      end
   end

   // A running sequence always belongs to a start or cold start mode.
   assert property (@(posedge clock) disable iff (reset)
      step_ff != spsu_pkg::STEP_IDLE |->
         (mode_ff == spsu_pkg::MODE_START || mode_ff == spsu_pkg::MODE_COLD))
      else $error("sequence step active outside start modes");

   // The mode entry has been performed before any phase runs.
   assert property (@(posedge clock) disable iff (reset)
      step_ff != spsu_pkg::STEP_IDLE |-> mode_ff == seen_ff)
      else $error("sequence running with a pending mode entry");

   // The power-on pulse is held high for the whole pulse phase.
   assert property (@(posedge clock) disable iff (reset)
      step_ff == spsu_pkg::STEP_C_PULSE |-> drive_ff.pwron_out)
      else $error("power-on pulse low during pulse phase");

   // The press timer only counts up, saturates, or restarts at zero.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> (press_ff == '0 || press_ff >= $past(press_ff)))
      else $error("press timer moved backward");

endmodule

FILE: hw/rtl/soc_power_sequencer_unit.sv
// ----------------------------------------------------------------------------
// SoC power sequencer
// Top level: input register, sequencer core, result register and the
// configuration registers.
// ----------------------------------------------------------------------------
// Usage: send one item per millisecond tick on the req_ channel; each item
// carries the sampled power button, reset-in, force-recovery and cold-start
// request levels. For every item exactly one result comes out on the rsp_
// channel, holding the drive levels, the SoC mode and the busy flag after
// that tick. The four tick counts are written on the csr_ channel while no
// item is in flight; csr_ready is always high.
// rsp_tvalid rises once the result of a req_ transfer is registered: the item
// sits in the input register and its result is loaded into the result
// register at the edge on which it advances. Throughput is one item per cycle
// while the receiver does not stall: an item moves from the input register
// into the result register as soon as the result register is empty or its
// content is taken in the same cycle, so a new item is accepted while a
// result waits as long as the input register is free. When the receiver
// stalls, the result register and then the input register fill and
// req_tready drops; nothing is lost. Reset clears both registers, puts the
// SoC in OFF with the PMIC held in reset and loads the default tick counts.
// ----------------------------------------------------------------------------
module soc_power_sequencer_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // power_btn, reset_in, force_recov, cold_start_req, then zero padding
   input  logic [spsu_pkg::ReqDataW-1:0]         req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // pwron_out, pmic_reset, reset_out, sd_enable, emmc_enable, qspi_enable,
   // soc_phase[2:0], busy_res, then zero padding
   output logic [spsu_pkg::RspDataW-1:0]         rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [spsu_pkg::CsrIndexW-1:0]        csr_index,
   input  logic [spsu_pkg::TickW-1:0]            csr_data
);

   localparam int ReqW = $bits(spsu_pkg::req_type);
   localparam int RspW = $bits(spsu_pkg::rsp_type);

   logic                in_valid_ff;
   spsu_pkg::req_type   in_data_ff;
   logic                rsp_valid_ff;
   spsu_pkg::rsp_type   rsp_data_ff;
   logic                advance;
   spsu_pkg::rsp_type   result;
   spsu_pkg::cfg_type   cfg;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   spsu_cfg_regs u_cfg (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   spsu_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_data_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata[ReqW-1:0];
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(spsu_pkg::RspDataW-RspW){1'b0}}, rsp_data_ff};

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// SoC power sequencer testbench
// Streams millisecond ticks of button, reset-in, force-recovery and
// cold-start levels into the sequencer and checks each returned set of drive
// levels, SoC mode and busy flag against a cycle-free model of the sequencer
// kept inside this bench. The tick counts are reprogrammed between runs,
// including their extremes, and both stream sides idle in random bursts.
// ----------------------------------------------------------------------------
module testbench;

   localparam int QuietLimit = 2000;
   localparam int HoldCap    = 40;

   logic                           clock;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [spsu_pkg::ReqDataW-1:0]  req_tdata  = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [spsu_pkg::RspDataW-1:0]  rsp_tdata;
   logic                           csr_valid  = 1'b0;
   logic                           csr_ready;
   logic [spsu_pkg::CsrIndexW-1:0] csr_index  = '0;
   logic [spsu_pkg::TickW-1:0]     csr_data   = '0;

   soc_power_sequencer_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Tick counts as the sequencer holds them, followed on every register write.
   spsu_pkg::cfg_type cfg = '{debounce_ticks: spsu_pkg::DEBOUNCE_RESET,
                              long_press_ticks: spsu_pkg::LONG_PRESS_RESET,
                              boot_delay_ticks: spsu_pkg::BOOT_DELAY_RESET,
                              pulse_ticks: spsu_pkg::PULSE_RESET};

   // Sequencer state as predicted from the accepted ticks.
   spsu_pkg::mode_type         p_mode      = spsu_pkg::MODE_OFF;
   spsu_pkg::mode_type         p_seen      = spsu_pkg::MODE_OFF;
   spsu_pkg::step_type         p_step      = spsu_pkg::STEP_IDLE;
   logic [spsu_pkg::TickW-1:0] p_seq_timer = '0;
   logic [spsu_pkg::TickW-1:0] p_press     = '0;
   logic                       p_btn_last  = 1'b1;
   logic                       p_rst_last  = 1'b1;
   logic                       p_recov     = 1'b0;
   spsu_pkg::drive_type        p_drive     = '{default: 1'b0, reset_out: 1'b1,
                                               pmic_reset: 1'b1};

   spsu_pkg::req_type tick_queue[$];
   spsu_pkg::rsp_type pending_levels[$];

   bit idle_on   = 1'b1;
   bit fr_pinned = 1'b0;
   bit cold_ok   = 1'b1;

   int req_gap       = 0;
   int rsp_stall     = 0;
   int quiet_cycles  = 0;
   int mismatches    = 0;
   int ticks_sent    = 0;
   int results_seen  = 0;
   int csr_writes    = 0;
   int settings_used = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void set_boot(logic sd, logic rest);
      p_drive.sd_enable   = sd;
      p_drive.emmc_enable = rest;
      p_drive.qspi_enable = rest;
   endfunction

   function automatic void close_sequence();
      p_step      = spsu_pkg::STEP_IDLE;
      p_seq_timer = '0;
      p_mode      = spsu_pkg::MODE_ON;
      p_seen      = spsu_pkg::MODE_ON;
   endfunction

   // Walks through every timed step whose wait has run out.
   function automatic void advance_phases();
      while (p_step != spsu_pkg::STEP_IDLE && p_seq_timer == 0) begin
         case (p_step)
            spsu_pkg::STEP_C_PULSE: begin
               p_drive.pwron_out = 1'b0;
               if (p_recov) set_boot(1'b1, 1'b1);
               p_step      = spsu_pkg::STEP_C_SETTLE;
               p_seq_timer = cfg.pulse_ticks;
            end
            spsu_pkg::STEP_C_SETTLE: begin
               p_drive.pmic_reset = 1'b0;
               if (p_recov) begin
                  close_sequence();
               end else begin
                  p_step      = spsu_pkg::STEP_C_BOOT;
                  p_seq_timer = cfg.boot_delay_ticks;
               end
            end
            default: begin
               set_boot(1'b1, 1'b1);
               close_sequence();
            end
         endcase
      end
   endfunction

   function automatic spsu_pkg::rsp_type next_levels(spsu_pkg::req_type t);
      spsu_pkg::rsp_type lv;
      if (p_press != spsu_pkg::TICK_MAX) p_press++;
      if (p_step != spsu_pkg::STEP_IDLE) begin
         if (p_seq_timer != 0) p_seq_timer--;
         advance_phases();
      end else begin
         if (t.cold_start_req) p_mode = spsu_pkg::MODE_COLD;
         if (p_mode != p_seen) begin
            p_seen = p_mode;
            case (p_mode)
               spsu_pkg::MODE_OFF: begin
                  p_drive.pmic_reset = 1'b1;
                  set_boot(1'b0, 1'b0);
               end
               spsu_pkg::MODE_RESET: begin
                  p_drive.pmic_reset = 1'b1;
                  set_boot(1'b0, 1'b0);
                  p_drive.reset_out = 1'b0;
               end
               spsu_pkg::MODE_START: begin
                  p_recov = t.force_recov;
                  p_drive.pmic_reset = 1'b0;
                  if (t.force_recov) begin
                     set_boot(1'b1, 1'b1);
                     close_sequence();
                  end else begin
                     set_boot(1'b1, 1'b0);
                     p_step      = spsu_pkg::STEP_S_BOOT;
                     p_seq_timer = cfg.boot_delay_ticks;
                     advance_phases();
                  end
               end
               spsu_pkg::MODE_COLD: begin
                  p_recov = t.force_recov;
                  p_drive.reset_out = 1'b1;
                  if (!t.force_recov) set_boot(1'b1, 1'b0);
                  p_drive.pwron_out = 1'b1;
                  p_step      = spsu_pkg::STEP_C_PULSE;
                  p_seq_timer = cfg.pulse_ticks;
                  advance_phases();
               end
               default: ;
            endcase
         end
      end
      // Edges are only looked at once no timed step is running.
      if (p_step == spsu_pkg::STEP_IDLE) begin
         p_drive.pwron_out = !t.power_btn;
         if (p_btn_last && !t.power_btn) begin
            p_press = '0;
         end else if (!p_btn_last && t.power_btn) begin
            if (p_press >= cfg.debounce_ticks && p_press < cfg.long_press_ticks) begin
               if (p_mode == spsu_pkg::MODE_OFF) p_mode = spsu_pkg::MODE_START;
            end else if (p_press >= cfg.long_press_ticks) begin
               p_mode = spsu_pkg::MODE_OFF;
            end
         end
         p_btn_last = t.power_btn;
         if (!p_rst_last && t.reset_in) begin
            if (p_mode == spsu_pkg::MODE_RESET) p_mode = spsu_pkg::MODE_START;
         end else if (p_rst_last && !t.reset_in) begin
            if (p_mode == spsu_pkg::MODE_ON) p_mode = spsu_pkg::MODE_RESET;
         end
         p_rst_last = t.reset_in;
      end
      lv.pwron_out   = p_drive.pwron_out;
      lv.pmic_reset  = p_drive.pmic_reset;
      lv.reset_out   = p_drive.reset_out;
      lv.sd_enable   = p_drive.sd_enable;
      lv.emmc_enable = p_drive.emmc_enable;
      lv.qspi_enable = p_drive.qspi_enable;
      lv.soc_phase   = p_mode;
      lv.busy_res    = (p_step != spsu_pkg::STEP_IDLE);
      return lv;
   endfunction

   function automatic void check_field(string name, logic [2:0] want, logic [2:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Tick sender.
   always @(posedge clock) begin : drive_ticks
      spsu_pkg::req_type nxt;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            pending_levels.push_back(next_levels(
               spsu_pkg::req_type'(req_tdata[$bits(spsu_pkg::req_type)-1:0])));
            ticks_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (tick_queue.size() != 0) begin
               nxt = tick_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= spsu_pkg::ReqDataW'(nxt);
               if (idle_on && $urandom_range(0, 7) == 0) req_gap = $urandom_range(1, 10);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result receiver and checker.
   always @(posedge clock) begin : check_levels
      spsu_pkg::rsp_type got;
      spsu_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = spsu_pkg::rsp_type'(rsp_tdata[$bits(spsu_pkg::rsp_type)-1:0]);
            results_seen++;
            if (pending_levels.size() == 0) begin
               $display("%0t: result with no tick outstanding, expected none, actual %h",
                        $time, got);
               mismatches++;
            end else begin
               want = pending_levels.pop_front();
               check_field("pwron_out", 3'(want.pwron_out), 3'(got.pwron_out));
               check_field("pmic_reset", 3'(want.pmic_reset), 3'(got.pmic_reset));
               check_field("reset_out", 3'(want.reset_out), 3'(got.reset_out));
               check_field("sd_enable", 3'(want.sd_enable), 3'(got.sd_enable));
               check_field("emmc_enable", 3'(want.emmc_enable), 3'(got.emmc_enable));
               check_field("qspi_enable", 3'(want.qspi_enable), 3'(got.qspi_enable));
               check_field("soc_phase", want.soc_phase, got.soc_phase);
               check_field("busy_res", 3'(want.busy_res), 3'(got.busy_res));
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_stall = $urandom_range(0, 9);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QuietLimit) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, pending_levels.size());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic add_tick(bit btn, bit rst, bit fr, bit cold);
      spsu_pkg::req_type t;
      t.power_btn      = btn;
      t.reset_in       = rst;
      t.force_recov    = fr | fr_pinned;
      t.cold_start_req = cold & cold_ok;
      tick_queue.push_back(t);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (tick_queue.size() != 0 || req_tvalid || pending_levels.size() != 0);
   endtask

   task automatic write_reg(logic [spsu_pkg::CsrIndexW-1:0] idx,
                            logic [spsu_pkg::TickW-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         spsu_pkg::REG_DEBOUNCE:   cfg.debounce_ticks   = val;
         spsu_pkg::REG_LONG_PRESS: cfg.long_press_ticks = val;
         spsu_pkg::REG_BOOT_DELAY: cfg.boot_delay_ticks = val;
         spsu_pkg::REG_PULSE:      cfg.pulse_ticks      = val;
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic set_ticks(logic [spsu_pkg::TickW-1:0] deb, logic [spsu_pkg::TickW-1:0] lim,
                            logic [spsu_pkg::TickW-1:0] boot,
                            logic [spsu_pkg::TickW-1:0] pulse);
      write_reg(spsu_pkg::REG_DEBOUNCE, deb);
      write_reg(spsu_pkg::REG_LONG_PRESS, lim);
      write_reg(spsu_pkg::REG_BOOT_DELAY, boot);
      write_reg(spsu_pkg::REG_PULSE, pulse);
      settings_used++;
   endtask

   // Sends released, idle ticks until no sequence runs, no mode entry is
   // pending and no edge is left open, so that new tick counts can be written.
   task automatic settle();
      wait_idle();
      while (p_step != spsu_pkg::STEP_IDLE || p_mode != p_seen || !p_btn_last ||
             !p_rst_last) begin
         add_tick(1'b1, 1'b1, 1'b1, 1'b0);
         wait_idle();
      end
   endtask

   // Press lengths cluster around the click and long-press thresholds.
   function automatic int pick_hold();
      int k;
      case ($urandom_range(0, 5))
         0: k = int'(cfg.debounce_ticks) - 1;
         1: k = int'(cfg.debounce_ticks);
         2: k = int'(cfg.long_press_ticks) - 1;
         3: k = int'(cfg.long_press_ticks);
         4: k = int'(cfg.long_press_ticks) + 1;
         default: k = $urandom_range(1, 12);
      endcase
      if (k < 1) k = 1;
      if (k > HoldCap) k = HoldCap;
      return k;
   endfunction

   task automatic add_session();
      int k;
      bit fr;
      fr = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
         3: begin
            repeat ($urandom_range(1, 4)) add_tick(1'b1, 1'b0, fr, 1'b0);
            add_tick(1'b1, 1'b1, fr, 1'b0);
         end
         4: begin
            add_tick(1'b1, 1'b1, fr, 1'b1);
            repeat ($urandom_range(0, 3)) add_tick(1'b1, 1'b1, fr, 1'b0);
         end
         5: repeat ($urandom_range(1, 6))
               add_tick(1'b1, 1'b1, 1'($urandom_range(0, 1)), 1'b0);
         6: repeat ($urandom_range(1, 5))
               add_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         7: begin
            k = pick_hold();
            repeat (k) add_tick(1'b0, 1'b0, fr, 1'b0);
            add_tick(1'b1, 1'b1, fr, 1'b0);
         end
         default: begin
            k = pick_hold();
            repeat (k) add_tick(1'b0, 1'b1, fr, 1'b0);
            add_tick(1'b1, 1'b1, fr, 1'b0);
         end
      endcase
   endtask

   task automatic run_phase(logic [spsu_pkg::TickW-1:0] deb, logic [spsu_pkg::TickW-1:0] lim,
                            logic [spsu_pkg::TickW-1:0] boot,
                            logic [spsu_pkg::TickW-1:0] pulse,
                            bit pin_fr, bit allow_cold, int count);
      set_ticks(deb, lim, boot, pulse);
      fr_pinned = pin_fr;
      cold_ok   = allow_cold;
      while (tick_queue.size() < count) add_session();
      settle();
      fr_pinned = 1'b0;
      cold_ok   = 1'b1;
   endtask

   initial begin : main
      logic [spsu_pkg::TickW-1:0] deb;
      logic [spsu_pkg::TickW-1:0] lim;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset levels and a click far too short for the default debounce.
      add_tick(1'b1, 1'b1, 1'b0, 1'b0);
      add_tick(1'b0, 1'b1, 1'b0, 1'b0);
      add_tick(1'b1, 1'b1, 1'b0, 1'b0);
      settle();

      // Directed walk: short click, start with boot delay, edges frozen while
      // busy, reset in and out with force recovery, long press, cold starts.
      set_ticks(16'd2, 16'd4, 16'd2, 16'd1);
      add_tick(1'b0, 1'b1, 1'b0, 1'b0);
      add_tick(1'b1, 1'b1, 1'b0, 1'b0);
      repeat (2) add_tick(1'b0, 1'b1, 1'b0, 1'b0);
      add_tick(1'b1, 1'b1, 1'b0, 1'b0);
      add_tick(1'b1, 1'b1, 1'b0, 1'b0);
      add_tick(1'b0, 1'b1, 1'b0, 1'b1);
      add_tick(1'b1, 1'b1, 1'b0, 1'b1);
      add_tick(1'b1, 1'b0, 1'b0, 1'b0);
      add_tick(1'b1, 1'b0, 1'b0, 1'b0);
      add_tick(1'b1, 1'b1, 1'b1, 1'b0);
      add_tick(1'b1, 1'b1, 1'b1, 1'b0);
      repeat (4) add_tick(1'b0, 1'b1, 1'b0, 1'b0);
      add_tick(1'b1, 1'b1, 1'b0, 1'b0);
      add_tick(1'b1, 1'b1, 1'b0, 1'b0);
      add_tick(1'b1, 1'b1, 1'b1, 1'b1);
      repeat (3) add_tick(1'b1, 1'b1, 1'b0, 1'b1);
      add_tick(1'b1, 1'b1, 1'b0, 1'b1);
      repeat (4) add_tick(1'b1, 1'b1, 1'b0, 1'b0);
      settle();

      run_phase(16'd2, 16'd4, 16'd2, 16'd1, 1'b0, 1'b1, 150);
      // All waits zero, and every release counts as a long press.
      run_phase(16'd0, 16'd1, 16'd0, 16'd0, 1'b0, 1'b1, 200);
      run_phase(16'd3, 16'd10, 16'd5, 16'd3, 1'b0, 1'b1, 220);
      // Debounce above the long-press length leaves no short click.
      run_phase(16'd6, 16'd4, 16'd1, 16'd2, 1'b0, 1'b1, 150);
      // Longest boot delay, never reached since force recovery is pinned set.
      run_phase(16'd1, 16'd8, spsu_pkg::TICK_MAX, 16'd3, 1'b1, 1'b1, 150);
      // Longest pulse, with cold starts kept out.
      run_phase(16'd1, 16'd8, 16'd4, spsu_pkg::TICK_MAX, 1'b0, 1'b0, 150);
      repeat (2) begin
         deb = spsu_pkg::TickW'($urandom_range(0, 6));
         lim = deb + spsu_pkg::TickW'($urandom_range(1, 12));
         run_phase(deb, lim, spsu_pkg::TickW'($urandom_range(0, 8)),
                   spsu_pkg::TickW'($urandom_range(0, 5)), 1'b0, 1'b1, 175);
      end

      idle_on = 1'b0;
      run_phase(16'd2, 16'd6, 16'd3, 16'd2, 1'b0, 1'b1, 200);
      repeat (10) @(posedge clock);

      if (pending_levels.size() != 0) begin
         $display("%0t: %0d results never arrived, expected 0, actual %0d", $time,
                  pending_levels.size(), pending_levels.size());
         mismatches++;
      end
      $display("Sent %0d ticks and checked %0d results over %0d tick-count settings",
               ticks_sent, results_seen, settings_used);
      $display("(%0d register writes), with %0d mismatches.", csr_writes, mismatches);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
